@@ hw/rtl/tjpt_pkg.sv @@
// Shared types, widths and the motor saturation helper for the two-joint tendon PID block.
package tjpt_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 12;
    localparam int RATIO_FRAC   = 14;
    localparam int GAIN_W       = 16;
    localparam int INTEG_W      = 32;
    localparam int TQ_LIMIT_W   = 44;

    // Lane datapath widths, sized for the products, sums and shifted values they hold.
    localparam int ERR_W = SAMPLE_WIDTH + 1;
    localparam int VC_W  = SAMPLE_WIDTH + 2;
    localparam int PD_W  = VC_W + GAIN_W + 1;
    localparam int D_W   = PD_W - RATIO_FRAC;
    localparam int PP_W  = ERR_W + GAIN_W + 1;
    localparam int PDD_W = D_W + GAIN_W + 1;
    localparam int PI_W  = INTEG_W + GAIN_W + 1;
    localparam int SUM_W = ((PI_W > PDD_W) ? PI_W : PDD_W) + 2;
    localparam int SH_W  = SUM_W - FRAC_BITS - 1;
    localparam int TQ_W  = (SH_W > TQ_LIMIT_W) ? TQ_LIMIT_W : SH_W;

    // Merge widths: the joint torque is split in two halves for the ratio products.
    localparam int LO_W  = TQ_W / 2;
    localparam int HI_W  = TQ_W - LO_W;
    localparam int PL_W  = GAIN_W + 1 + LO_W + 1;
    localparam int PH_W  = GAIN_W + 1 + HI_W;
    localparam int P_W   = TQ_W + GAIN_W + 1;
    localparam int ACC_W = P_W + 1;

    localparam int          CNT_W    = 3;
    localparam logic [CNT_W-1:0] RUN_LAST = CNT_W'(6);
    localparam int          IDX_W    = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_PROP   = 3'd0,
        REG_HIGH_PROP  = 3'd1,
        REG_LOW_DERIV  = 3'd2,
        REG_HIGH_DERIV = 3'd3,
        REG_LOW_INTEG  = 3'd4,
        REG_HIGH_INTEG = 3'd5,
        REG_RATIO_ONE  = 3'd6,
        REG_RATIO_TWO  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] pos_joint_a;
        logic signed [SAMPLE_WIDTH-1:0] pos_joint_b;
        logic signed [SAMPLE_WIDTH-1:0] goal_joint_a;
        logic signed [SAMPLE_WIDTH-1:0] goal_joint_b;
        logic signed [SAMPLE_WIDTH-1:0] vel_motor_a;
        logic signed [SAMPLE_WIDTH-1:0] vel_motor_b;
        logic signed [SAMPLE_WIDTH-1:0] vel_motor_c;
        logic signed [SAMPLE_WIDTH-1:0] vel_motor_d;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] drive_motor_a;
        logic signed [SAMPLE_WIDTH-1:0] drive_motor_b;
        logic signed [SAMPLE_WIDTH-1:0] drive_motor_c;
        logic signed [SAMPLE_WIDTH-1:0] drive_motor_d;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0] low_prop_gain;
        logic [GAIN_W-1:0] high_prop_gain;
        logic [GAIN_W-1:0] low_deriv_gain;
        logic [GAIN_W-1:0] high_deriv_gain;
        logic [GAIN_W-1:0] low_integ_gain;
        logic [GAIN_W-1:0] high_integ_gain;
        logic [GAIN_W-1:0] pulley_ratio_one;
        logic [GAIN_W-1:0] pulley_ratio_two;
    } t_cfg;

    // Gains and tendon ratio that one joint lane works with.
    typedef struct packed {
        logic [GAIN_W-1:0] prop_lo;
        logic [GAIN_W-1:0] prop_hi;
        logic [GAIN_W-1:0] deriv_lo;
        logic [GAIN_W-1:0] deriv_hi;
        logic [GAIN_W-1:0] integ_lo;
        logic [GAIN_W-1:0] integ_hi;
        logic [GAIN_W-1:0] ratio;
    } t_lane_gains;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] pos;
        logic signed [SAMPLE_WIDTH-1:0] goal;
        logic signed [VC_W-1:0]         vel_comb;
    } t_lane_in;

    // Floor shift by the ratio fraction, then clamp to the motor output range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_motor(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0]          sh;
        logic [ACC_W-SAMPLE_WIDTH:0]      top;
        sh  = acc >>> RATIO_FRAC;
        top = sh[ACC_W-1:SAMPLE_WIDTH-1];
        if ((&top) || !(|top)) begin
            sat_motor = sh[SAMPLE_WIDTH-1:0];
        end else if (sh[ACC_W-1]) begin
            sat_motor = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            sat_motor = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

@@ hw/rtl/tjpt_lane.sv @@
// One joint lane: error, saturating integral, gain schedule and PID sum.
module tjpt_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_upd,
    input  logic                                i_quarter,
    input  tjpt_pkg::t_lane_in                  i_lane,
    input  tjpt_pkg::t_lane_gains               i_gains,
    output logic signed [tjpt_pkg::TQ_W-1:0]    o_torque
);

    logic signed [tjpt_pkg::ERR_W-1:0]   err;
    logic signed [tjpt_pkg::INTEG_W:0]   integ_sum;
    logic signed [tjpt_pkg::INTEG_W-1:0] n_integ;

    logic signed [tjpt_pkg::ERR_W-1:0]   r_err;
    logic signed [tjpt_pkg::VC_W-1:0]    r_vc;
    logic                                r_hi;
    logic signed [tjpt_pkg::INTEG_W-1:0] r_integ;
    logic signed [tjpt_pkg::PD_W-1:0]    r_pd;
    logic signed [tjpt_pkg::PP_W-1:0]    r_pp;
    logic signed [tjpt_pkg::PI_W-1:0]    r_pi;
    logic signed [tjpt_pkg::PDD_W-1:0]   r_pdd;
    logic signed [tjpt_pkg::TQ_W-1:0]    r_torque;

    logic signed [tjpt_pkg::GAIN_W:0]    kp;
    logic signed [tjpt_pkg::GAIN_W:0]    kd;
    logic signed [tjpt_pkg::GAIN_W:0]    ki;
    logic signed [tjpt_pkg::GAIN_W:0]    ratio;
    logic signed [tjpt_pkg::D_W-1:0]     deriv;
    logic signed [tjpt_pkg::SUM_W-1:0]   sum;
    logic signed [tjpt_pkg::SUM_W-1:0]   sum_sh;
    logic signed [tjpt_pkg::SH_W-1:0]    sh;
    logic [tjpt_pkg::SH_W-tjpt_pkg::TQ_W:0] tq_top;
    logic signed [tjpt_pkg::TQ_W-1:0]    n_torque;

    assign err = tjpt_pkg::ERR_W'(i_lane.goal) - tjpt_pkg::ERR_W'(i_lane.pos);

    // Integral add saturates to the signed 32-bit range.
    assign integ_sum    = (tjpt_pkg::INTEG_W + 1)'(r_integ) + (tjpt_pkg::INTEG_W + 1)'(err);
    always_comb begin
        if (integ_sum[tjpt_pkg::INTEG_W] == integ_sum[tjpt_pkg::INTEG_W-1]) begin
            n_integ = integ_sum[tjpt_pkg::INTEG_W-1:0];
        end else if (integ_sum[tjpt_pkg::INTEG_W]) begin
            n_integ = {1'b1, {(tjpt_pkg::INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(tjpt_pkg::INTEG_W-1){1'b1}}};
        end
    end

    // Zero error counts as non-positive and takes the low gain set.
    assign kp    = $signed({1'b0, r_hi ? i_gains.prop_hi  : i_gains.prop_lo});
    assign kd    = $signed({1'b0, r_hi ? i_gains.deriv_hi : i_gains.deriv_lo});
    assign ki    = $signed({1'b0, r_hi ? i_gains.integ_hi : i_gains.integ_lo});
    assign ratio = $signed({1'b0, i_gains.ratio});
    assign deriv = r_pd[tjpt_pkg::PD_W-1:tjpt_pkg::RATIO_FRAC];

    assign sum = tjpt_pkg::SUM_W'(r_pp) + tjpt_pkg::SUM_W'(r_pdd) + tjpt_pkg::SUM_W'(r_pi);
    assign sum_sh = i_quarter ? (sum >>> (tjpt_pkg::FRAC_BITS + 2))
                              : (sum >>> (tjpt_pkg::FRAC_BITS + 1));
    assign sh     = sum_sh[tjpt_pkg::SH_W-1:0];
    assign tq_top = sh[tjpt_pkg::SH_W-1:tjpt_pkg::TQ_W-1];

    always_comb begin
        if ((&tq_top) || !(|tq_top)) begin
            n_torque = sh[tjpt_pkg::TQ_W-1:0];
        end else if (sh[tjpt_pkg::SH_W-1]) begin
            n_torque = {1'b1, {(tjpt_pkg::TQ_W-1){1'b0}}};
        end else begin
            n_torque = {1'b0, {(tjpt_pkg::TQ_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_upd) begin
            r_integ <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err    <= err;
        r_hi     <= (err > 0);
        r_vc     <= i_lane.vel_comb;
        r_pd     <= ratio * r_vc;
        r_pp     <= kp * r_err;
        r_pi     <= ki * r_integ;
        r_pdd    <= kd * deriv;
        r_torque <= n_torque;
    end

    assign o_torque = r_torque;

endmodule

@@ hw/rtl/tjpt_merge.sv @@
// Merging stage: maps the two joint torques through the tendon matrix to four motors.
module tjpt_merge (
    input  logic                                i_clk,
    input  logic signed [tjpt_pkg::TQ_W-1:0]    i_torque_a,
    input  logic signed [tjpt_pkg::TQ_W-1:0]    i_torque_b,
    input  logic [tjpt_pkg::GAIN_W-1:0]         i_ratio_one,
    input  logic [tjpt_pkg::GAIN_W-1:0]         i_ratio_two,
    output tjpt_pkg::t_out_item                 o_drive
);

    logic signed [tjpt_pkg::GAIN_W:0]  ratio_one;
    logic signed [tjpt_pkg::GAIN_W:0]  ratio_two;
    logic signed [tjpt_pkg::PL_W-1:0]  r_pl_a;
    logic signed [tjpt_pkg::PL_W-1:0]  r_pl_b;
    logic signed [tjpt_pkg::PH_W-1:0]  r_ph_a;
    logic signed [tjpt_pkg::PH_W-1:0]  r_ph_b;
    logic signed [tjpt_pkg::P_W-1:0]   r_p_a;
    logic signed [tjpt_pkg::P_W-1:0]   r_p_b;
    logic signed [tjpt_pkg::ACC_W-1:0] p_a;
    logic signed [tjpt_pkg::ACC_W-1:0] p_b;

    assign ratio_one = $signed({1'b0, i_ratio_one});
    assign ratio_two = $signed({1'b0, i_ratio_two});

    // Each ratio product is built from a low and a high half of the torque.
    always_ff @(posedge i_clk) begin
        r_pl_a <= ratio_one * $signed({1'b0, i_torque_a[tjpt_pkg::LO_W-1:0]});
        r_ph_a <= ratio_one * $signed(i_torque_a[tjpt_pkg::TQ_W-1:tjpt_pkg::LO_W]);
        r_pl_b <= ratio_two * $signed({1'b0, i_torque_b[tjpt_pkg::LO_W-1:0]});
        r_ph_b <= ratio_two * $signed(i_torque_b[tjpt_pkg::TQ_W-1:tjpt_pkg::LO_W]);
        r_p_a  <= (tjpt_pkg::P_W'(r_ph_a) <<< tjpt_pkg::LO_W) + tjpt_pkg::P_W'(r_pl_a);
        r_p_b  <= (tjpt_pkg::P_W'(r_ph_b) <<< tjpt_pkg::LO_W) + tjpt_pkg::P_W'(r_pl_b);
    end

    assign p_a = tjpt_pkg::ACC_W'(r_p_a);
    assign p_b = tjpt_pkg::ACC_W'(r_p_b);

    always_comb begin
        o_drive.drive_motor_a = tjpt_pkg::sat_motor(p_a + p_b);
        o_drive.drive_motor_b = tjpt_pkg::sat_motor(p_b - p_a);
        o_drive.drive_motor_c = tjpt_pkg::sat_motor(-p_b);
        o_drive.drive_motor_d = tjpt_pkg::sat_motor(p_b);
    end

endmodule

@@ hw/rtl/two_joint_pid_tendon_torque.sv @@
// Usage notes:
// Two-joint gain-scheduled PID controller with a tendon-driven motor map.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one control
// tick: two joint positions, two goals and four motor velocities. Output
// channel (o_out_valid / i_out_ready / o_out_data) carries the four motor
// torques of that tick. Gains and pulley ratios are written through the
// plain write port (i_cfg_wr_en, i_cfg_idx, i_cfg_data). The user must only
// write them while the block is idle; the block itself does not enforce this.
// One transaction is worked on at a time. Its result is loaded into the output
// register after the four lane stages (error and integral, multiply, derivative
// multiply, PID sum) and the merge stages.
// A new input transaction can be taken in the cycle after the result is
// loaded, so a new tick is never taken before the last one is finished.
// If the receiver stalls, a finished result waits in the output register and
// the next transaction can still be accepted; its result is held inside until
// the output register frees, and no further input is taken meanwhile.
// Synchronous reset clears both joint integrals, loads the default gains and
// ratios, returns the control to idle and marks the output register empty.
module two_joint_pid_tendon_torque (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tjpt_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tjpt_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_wr_en,
    input  logic [tjpt_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [tjpt_pkg::GAIN_W-1:0]     i_cfg_data
);

    tjpt_pkg::t_state    r_state;
    tjpt_pkg::t_state    n_state;
    logic [tjpt_pkg::CNT_W-1:0] r_cnt;
    tjpt_pkg::t_cfg      r_cfg;
    tjpt_pkg::t_in_item  r_in;
    tjpt_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic                in_accept;
    logic                out_free;
    logic                upd;
    logic                load;

    tjpt_pkg::t_lane_in    lane_a;
    tjpt_pkg::t_lane_in    lane_b;
    tjpt_pkg::t_lane_gains gains_a;
    tjpt_pkg::t_lane_gains gains_b;
    logic signed [tjpt_pkg::TQ_W-1:0] torque_a;
    logic signed [tjpt_pkg::TQ_W-1:0] torque_b;
    tjpt_pkg::t_out_item   drive;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tjpt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = tjpt_pkg::ST_RUN;
                end
            end
            tjpt_pkg::ST_RUN: begin
                if (r_cnt == tjpt_pkg::RUN_LAST) begin
                    n_state = out_free ? tjpt_pkg::ST_IDLE : tjpt_pkg::ST_HOLD;
                end
            end
            tjpt_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_state = tjpt_pkg::ST_IDLE;
                end
            end
            default: n_state = tjpt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == tjpt_pkg::ST_IDLE);
        upd        = (r_state == tjpt_pkg::ST_RUN) && (r_cnt == '0);
        load       = out_free && ((r_state == tjpt_pkg::ST_HOLD) ||
                     ((r_state == tjpt_pkg::ST_RUN) && (r_cnt == tjpt_pkg::RUN_LAST)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tjpt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tjpt_pkg::ST_RUN && r_cnt != tjpt_pkg::RUN_LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == tjpt_pkg::ST_IDLE) begin
                r_cnt <= '0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_prop_gain    <= 16'd1843;
            r_cfg.high_prop_gain   <= 16'd2662;
            r_cfg.low_deriv_gain   <= 16'd410;
            r_cfg.high_deriv_gain  <= 16'd819;
            r_cfg.low_integ_gain   <= 16'd0;
            r_cfg.high_integ_gain  <= 16'd0;
            r_cfg.pulley_ratio_one <= 16'd16384;
            r_cfg.pulley_ratio_two <= 16'd16384;
        end else if (i_cfg_wr_en) begin
            unique case (tjpt_pkg::t_reg_idx'(i_cfg_idx))
                tjpt_pkg::REG_LOW_PROP:   r_cfg.low_prop_gain    <= i_cfg_data;
                tjpt_pkg::REG_HIGH_PROP:  r_cfg.high_prop_gain   <= i_cfg_data;
                tjpt_pkg::REG_LOW_DERIV:  r_cfg.low_deriv_gain   <= i_cfg_data;
                tjpt_pkg::REG_HIGH_DERIV: r_cfg.high_deriv_gain  <= i_cfg_data;
                tjpt_pkg::REG_LOW_INTEG:  r_cfg.low_integ_gain   <= i_cfg_data;
                tjpt_pkg::REG_HIGH_INTEG: r_cfg.high_integ_gain  <= i_cfg_data;
                tjpt_pkg::REG_RATIO_ONE:  r_cfg.pulley_ratio_one <= i_cfg_data;
                tjpt_pkg::REG_RATIO_TWO:  r_cfg.pulley_ratio_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (load) begin
            r_out <= drive;
        end
    end

    // Tendon velocity combinations that feed the joint derivatives.
    always_comb begin
        lane_a.pos      = r_in.pos_joint_a;
        lane_a.goal     = r_in.goal_joint_a;
        lane_a.vel_comb = tjpt_pkg::VC_W'(r_in.vel_motor_a) - tjpt_pkg::VC_W'(r_in.vel_motor_b);
        lane_b.pos      = r_in.pos_joint_b;
        lane_b.goal     = r_in.goal_joint_b;
        lane_b.vel_comb = tjpt_pkg::VC_W'(r_in.vel_motor_a) + tjpt_pkg::VC_W'(r_in.vel_motor_b)
                        - tjpt_pkg::VC_W'(r_in.vel_motor_c) + tjpt_pkg::VC_W'(r_in.vel_motor_d);
    end

    always_comb begin
        gains_a.prop_lo  = r_cfg.low_prop_gain;
        gains_a.prop_hi  = r_cfg.high_prop_gain;
        gains_a.deriv_lo = r_cfg.low_deriv_gain;
        gains_a.deriv_hi = r_cfg.high_deriv_gain;
        gains_a.integ_lo = r_cfg.low_integ_gain;
        gains_a.integ_hi = r_cfg.high_integ_gain;
        gains_a.ratio    = r_cfg.pulley_ratio_one;
        gains_b          = gains_a;
        gains_b.ratio    = r_cfg.pulley_ratio_two;
    end

    tjpt_lane u_lane_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_quarter (1'b0),
        .i_lane    (lane_a),
        .i_gains   (gains_a),
        .o_torque  (torque_a)
    );

    tjpt_lane u_lane_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_quarter (1'b1),
        .i_lane    (lane_b),
        .i_gains   (gains_b),
        .o_torque  (torque_b)
    );

    tjpt_merge u_merge (
        .i_clk       (i_clk),
        .i_torque_a  (torque_a),
        .i_torque_b  (torque_b),
        .i_ratio_one (r_cfg.pulley_ratio_one),
        .i_ratio_two (r_cfg.pulley_ratio_two),
        .o_drive     (drive)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/tjpt_checker.sv @@
// Port-level checker for the two-joint tendon PID block, with its bind.
module tjpt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tjpt_pkg::t_out_item o_out_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // Only one transaction is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a transaction is in flight");

    // The result passes through the pipeline registers, so no result can follow an accept at once.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared right after input transaction");

endmodule

bind two_joint_pid_tendon_torque tjpt_checker u_tjpt_checker (.*);

@@ bench/two_joint_pid_tendon_torque_tb.sv @@
// Self-checking testbench for the two-joint tendon PID torque block.
`timescale 1ns / 1ps

module two_joint_pid_tendon_torque_tb;

    localparam int  TICKS_PER_PHASE = 300;
    localparam int  TAIL_CYCLES     = 16;
    localparam int  CYCLE_LIMIT     = 3000000;
    localparam int  DIR_ROWS        = 19;

    localparam logic signed [tjpt_pkg::SAMPLE_WIDTH-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [tjpt_pkg::SAMPLE_WIDTH-1:0] S_MIN = 16'sh8000;

    localparam longint INTEG_MAX  = 64'sd2147483647;
    localparam longint INTEG_MIN  = -64'sd2147483648;
    localparam longint TORQUE_CAP = 64'sd1 <<< (tjpt_pkg::TQ_LIMIT_W - 1);
    localparam longint DRIVE_MAX  = (64'sd1 <<< (tjpt_pkg::SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint DRIVE_MIN  = -DRIVE_MAX - 64'sd1;

    localparam tjpt_pkg::t_cfg DEFAULT_GAINS = '{16'd1843, 16'd2662, 16'd410, 16'd819,
                                                 16'd0, 16'd0, 16'd16384, 16'd16384};
    localparam tjpt_pkg::t_cfg FULL_GAINS    = '1;
    localparam tjpt_pkg::t_cfg NULL_GAINS    = '{16'd0, 16'd0, 16'd0, 16'd0,
                                                 16'd0, 16'd0, 16'd16384, 16'd16384};
    localparam tjpt_pkg::t_cfg SLACK_TENDONS = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                                 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    localparam tjpt_pkg::t_cfg INTEG_GAINS   = '{16'd1843, 16'd2662, 16'd410, 16'd819,
                                                 16'd300, 16'd5000, 16'd16384, 16'd8192};

    typedef enum bit {ROW_TICK, ROW_GAINS} t_row_kind;

    typedef enum logic [2:0] {
        STYLE_DEFAULT,
        STYLE_WIDE,
        STYLE_TYPICAL,
        STYLE_EDGES,
        STYLE_NO_INTEG
    } t_gain_style;

    typedef struct packed {
        t_row_kind           kind;
        tjpt_pkg::t_cfg      gains;
        tjpt_pkg::t_in_item  tick;
        bit                  typed;
        tjpt_pkg::t_out_item want;
    } t_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    tjpt_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tjpt_pkg::t_out_item out_data;
    logic                cfg_wr_en = 1'b0;
    tjpt_pkg::t_reg_idx  cfg_idx   = tjpt_pkg::REG_LOW_PROP;
    logic [tjpt_pkg::GAIN_W-1:0] cfg_data = '0;

    tjpt_pkg::t_out_item torque_queue [$];
    tjpt_pkg::t_cfg      gain_set  = DEFAULT_GAINS;
    longint    integ_a   = 0;
    longint    integ_b   = 0;
    int        fault_count = 0;
    int        cycle_count = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    t_gain_style phase_styles [5] = '{STYLE_DEFAULT, STYLE_WIDE, STYLE_TYPICAL,
                                      STYLE_EDGES, STYLE_NO_INTEG};

    // Integrals entering the saturation rows are a = 1 and b = 65534, so both
    // joint torques are huge and every motor output clips.
    t_row directed_rows [DIR_ROWS] = '{
        '{ROW_TICK, '0, '0, 1'b1, '0},
        '{ROW_TICK, '0, '{S_MIN, 16'sd0, S_MAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b0, '0},
        '{ROW_TICK, '0, '{S_MAX, 16'sd0, S_MIN, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
          1'b0, '0},
        '{ROW_TICK, '0, '{16'sd0, S_MIN, 16'sd0, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX},
          1'b0, '0},
        '{ROW_TICK, '0, '{16'sh1234, 16'sh8001, 16'sh1234, 16'sh8001,
                          16'sh0400, 16'shFC00, 16'sh0100, 16'sh7000}, 1'b0, '0},
        '{ROW_TICK, '0, '{16'sd0, 16'sd1, 16'sd1, 16'sd0, -16'sd1, 16'sd1, -16'sd1, 16'sd1},
          1'b0, '0},
        '{ROW_GAINS, FULL_GAINS, '0, 1'b0, '0},
        '{ROW_TICK, '0, '{S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX},
          1'b1, '{S_MAX, S_MIN, S_MIN, S_MAX}},
        '{ROW_TICK, '0, '{S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN},
          1'b1, '{S_MIN, S_MAX, S_MAX, S_MIN}},
        '{ROW_GAINS, NULL_GAINS, '0, 1'b0, '0},
        '{ROW_TICK, '0, '{16'sh4000, 16'shC000, S_MIN, S_MAX, S_MAX, S_MAX, S_MIN, S_MAX},
          1'b1, '0},
        '{ROW_GAINS, SLACK_TENDONS, '0, 1'b0, '0},
        '{ROW_TICK, '0, '{S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN},
          1'b1, '0},
        '{ROW_GAINS, INTEG_GAINS, '0, 1'b0, '0},
        '{ROW_TICK, '0, '{16'sh0800, 16'sh0100, 16'sh0C00, 16'sh0000,
                          16'sh0200, 16'shFF00, 16'sh0010, 16'sh0040}, 1'b0, '0},
        '{ROW_TICK, '0, '{16'sh0C00, 16'shF000, 16'sh0C00, 16'shE000,
                          16'shF800, 16'sh0800, 16'sh0000, 16'sh0100}, 1'b0, '0},
        '{ROW_GAINS, DEFAULT_GAINS, '0, 1'b0, '0},
        '{ROW_TICK, '0, '{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
                          16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, '0},
        '{ROW_TICK, '0, '{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA,
                          16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b0, '0}
    };

    two_joint_pid_tendon_torque dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // Picks the gain set by the sign of the error; zero error uses the low set.
    function automatic longint joint_torque_of(input longint err, input longint deriv,
                                               inout longint integ, input int halvings);
        longint kp, kd, ki, pid;
        if (err > 0) begin
            kp = gain_set.high_prop_gain;
            kd = gain_set.high_deriv_gain;
            ki = gain_set.high_integ_gain;
        end else begin
            kp = gain_set.low_prop_gain;
            kd = gain_set.low_deriv_gain;
            ki = gain_set.low_integ_gain;
        end
        integ = clip(integ + err, INTEG_MIN, INTEG_MAX);
        pid = kp * err + kd * deriv + ki * integ;
        return clip(pid >>> (tjpt_pkg::FRAC_BITS + halvings), -TORQUE_CAP, TORQUE_CAP - 1);
    endfunction

    function automatic logic signed [tjpt_pkg::SAMPLE_WIDTH-1:0] motor_drive(
        input longint acc
    );
        longint v;
        v = clip(acc >>> tjpt_pkg::RATIO_FRAC, DRIVE_MIN, DRIVE_MAX);
        return v[tjpt_pkg::SAMPLE_WIDTH-1:0];
    endfunction

    function automatic tjpt_pkg::t_out_item predict_torques(input tjpt_pkg::t_in_item tick);
        longint r1, r2, va, vb, vc, vd, deriv_a, deriv_b, t0, t1;
        tjpt_pkg::t_out_item res;
        r1 = gain_set.pulley_ratio_one;
        r2 = gain_set.pulley_ratio_two;
        va = longint'($signed(tick.vel_motor_a));
        vb = longint'($signed(tick.vel_motor_b));
        vc = longint'($signed(tick.vel_motor_c));
        vd = longint'($signed(tick.vel_motor_d));
        deriv_a = (r1 * (va - vb)) >>> tjpt_pkg::RATIO_FRAC;
        deriv_b = (r2 * (va + vb - vc + vd)) >>> tjpt_pkg::RATIO_FRAC;
        t0 = joint_torque_of(longint'($signed(tick.goal_joint_a))
                             - longint'($signed(tick.pos_joint_a)), deriv_a, integ_a, 1);
        t1 = joint_torque_of(longint'($signed(tick.goal_joint_b))
                             - longint'($signed(tick.pos_joint_b)), deriv_b, integ_b, 2);
        res.drive_motor_a = motor_drive(r1 * t0 + r2 * t1);
        res.drive_motor_b = motor_drive(r2 * t1 - r1 * t0);
        res.drive_motor_c = motor_drive(-(r2 * t1));
        res.drive_motor_d = motor_drive(r2 * t1);
        return res;
    endfunction

    // Back-to-back half the time, otherwise usually a short gap, rarely a long pause.
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [tjpt_pkg::SAMPLE_WIDTH-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            1, 2: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic tjpt_pkg::t_in_item draw_tick();
        tjpt_pkg::t_in_item t;
        t.pos_joint_a  = draw_sample();
        t.pos_joint_b  = draw_sample();
        t.goal_joint_a = draw_sample();
        t.goal_joint_b = draw_sample();
        t.vel_motor_a  = draw_sample();
        t.vel_motor_b  = draw_sample();
        t.vel_motor_c  = draw_sample();
        t.vel_motor_d  = draw_sample();
        case ($urandom_range(0, 15))
            0: t.goal_joint_a = t.pos_joint_a;
            1: t.goal_joint_a = t.pos_joint_a + 16'sd1;
            default: ;
        endcase
        case ($urandom_range(0, 15))
            0: t.goal_joint_b = t.pos_joint_b;
            1: t.goal_joint_b = t.pos_joint_b - 16'sd1;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [tjpt_pkg::GAIN_W-1:0] draw_gain(input t_gain_style s,
                                                              input bit ratio);
        case (s)
            STYLE_WIDE: return 16'($urandom());
            STYLE_TYPICAL: begin
                if (ratio) return 16'($urandom_range(8192, 32768));
                return 16'($urandom_range(0, 8191));
            end
            STYLE_EDGES: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return 16'($urandom());
                endcase
            end
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic void log_fault(input string what, input tjpt_pkg::t_out_item want,
                                      input tjpt_pkg::t_out_item got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s: expected %0d %0d %0d %0d, got %0d %0d %0d %0d", what,
                     want.drive_motor_a, want.drive_motor_b, want.drive_motor_c,
                     want.drive_motor_d, got.drive_motor_a, got.drive_motor_b,
                     got.drive_motor_c, got.drive_motor_d);
        end
    endfunction

    task automatic write_reg(input tjpt_pkg::t_reg_idx idx,
                             input logic [tjpt_pkg::GAIN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_gains(input tjpt_pkg::t_cfg g);
        write_reg(tjpt_pkg::REG_LOW_PROP, g.low_prop_gain);
        write_reg(tjpt_pkg::REG_HIGH_PROP, g.high_prop_gain);
        write_reg(tjpt_pkg::REG_LOW_DERIV, g.low_deriv_gain);
        write_reg(tjpt_pkg::REG_HIGH_DERIV, g.high_deriv_gain);
        write_reg(tjpt_pkg::REG_LOW_INTEG, g.low_integ_gain);
        write_reg(tjpt_pkg::REG_HIGH_INTEG, g.high_integ_gain);
        write_reg(tjpt_pkg::REG_RATIO_ONE, g.pulley_ratio_one);
        write_reg(tjpt_pkg::REG_RATIO_TWO, g.pulley_ratio_two);
        cfg_wr_en <= 1'b0;
        gain_set = g;
    endtask

    // Called on a rising edge; returns on the edge where the transaction is taken.
    task automatic send_tick(input tjpt_pkg::t_in_item tick, input bit typed,
                             input tjpt_pkg::t_out_item want);
        int gap;
        tjpt_pkg::t_out_item model;
        gap = tx_steady ? 0 : draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        model = predict_torques(tick);
        torque_queue.push_back(typed ? want : model);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (torque_queue.size() != 0) @(posedge clk);
    endtask

    initial begin : receiver
        int n;
        @(posedge clk);
        forever begin
            if (rx_steady) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                n = draw_gap();
                if (n > 0) begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : check_torques
        tjpt_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (torque_queue.size() == 0) begin
                log_fault("unexpected result", '0, out_data);
            end else begin
                want = torque_queue.pop_front();
                if (out_data.drive_motor_a !== want.drive_motor_a ||
                    out_data.drive_motor_b !== want.drive_motor_b ||
                    out_data.drive_motor_c !== want.drive_motor_c ||
                    out_data.drive_motor_d !== want.drive_motor_d) begin
                    log_fault("torque mismatch", want, out_data);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        tjpt_pkg::t_cfg gains;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_GAINS) begin
                settle();
                load_gains(directed_rows[i].gains);
            end else begin
                send_tick(directed_rows[i].tick, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        foreach (phase_styles[p]) begin
            settle();
            if (phase_styles[p] == STYLE_DEFAULT) begin
                gains = DEFAULT_GAINS;
            end else begin
                gains.low_prop_gain    = draw_gain(phase_styles[p], 1'b0);
                gains.high_prop_gain   = draw_gain(phase_styles[p], 1'b0);
                gains.low_deriv_gain   = draw_gain(phase_styles[p], 1'b0);
                gains.high_deriv_gain  = draw_gain(phase_styles[p], 1'b0);
                gains.low_integ_gain   = draw_gain(phase_styles[p], 1'b0);
                gains.high_integ_gain  = draw_gain(phase_styles[p], 1'b0);
                gains.pulley_ratio_one = draw_gain(phase_styles[p], 1'b1);
                gains.pulley_ratio_two = draw_gain(phase_styles[p], 1'b1);
                if (phase_styles[p] == STYLE_NO_INTEG) begin
                    gains.low_integ_gain  = '0;
                    gains.high_integ_gain = '0;
                end
            end
            load_gains(gains);
            tx_steady = (phase_styles[p] == STYLE_EDGES);
            rx_steady = tx_steady;
            repeat (TICKS_PER_PHASE) send_tick(draw_tick(), 1'b0, '0);
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (40) send_tick(draw_tick(), 1'b0, '0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
